### sv/hbra_pkg.sv
// Histogram bin range aligner: shared widths and the divider-to-back word.
// No dependencies.
`default_nettype none
package hbra_pkg;

  localparam int HW_W  = 32;
  localparam int DIV_W = 49;
  localparam int LIM_W = 52;
  localparam int SLK_W = 38;
  localparam int OUT_W = 48;
  localparam int CNT_W = 16;
  localparam int MAG_H = 26;
  localparam int PRD_W = 84;

  typedef logic signed [LIM_W-1:0] lim_t;
  typedef logic signed [SLK_W-1:0] slk_t;

  typedef struct packed {
    logic [DIV_W-1:0] qmin;
    logic [HW_W-1:0]  rmin;
    logic             nmin;
    logic [DIV_W-1:0] qmax;
    logic [HW_W-1:0]  rmax;
    logic             nmax;
    logic [HW_W-1:0]  hw;
  } hbra_div_t;

endpackage
`default_nettype wire

### sv/hbra_front.sv
// Front end: input register, magnitude split and two pipelined restoring dividers.
// Depends on hbra_pkg.
`default_nettype none
module hbra_front import hbra_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    take,
  input  wire logic [HW_W-1:0]         req_width,
  input  wire logic signed [OUT_W-1:0] data_min,
  input  wire logic signed [OUT_W-1:0] data_max,
  output logic                         fr_valid,
  output hbra_div_t                    fr_word
);

  localparam int STG = DIV_W;

  typedef struct packed {
    logic [DIV_W-1:0] nmin;
    logic [HW_W-1:0]  rmin;
    logic             smin;
    logic [DIV_W-1:0] nmax;
    logic [HW_W-1:0]  rmax;
    logic             smax;
    logic [HW_W-1:0]  hw;
  } stg_t;

  stg_t sd_r [0:STG];
  logic sv_r [0:STG];
  stg_t sd_nxt0;

  function automatic logic [HW_W+DIV_W-1:0] div_step(input logic [HW_W-1:0] r,
      input logic [DIV_W-1:0] n, input logic [HW_W-1:0] d);
    logic [HW_W:0]   t;
    logic [HW_W-1:0] rn;
    logic            qb;
    t = {r, n[DIV_W-1]};
    if (t >= {1'b0, d}) begin
      rn = HW_W'(t - {1'b0, d});
      qb = 1'b1;
    end else begin
      rn = t[HW_W-1:0];
      qb = 1'b0;
    end
    return {rn, n[DIV_W-2:0], qb};
  endfunction

  always_comb begin
    logic signed [DIV_W-1:0] mn2, mx2;
    mn2 = {data_min, 1'b0};
    mx2 = {data_max, 1'b0};
    sd_nxt0.smin = mn2[DIV_W-1];
    sd_nxt0.smax = mx2[DIV_W-1];
    sd_nxt0.nmin = mn2[DIV_W-1] ? DIV_W'(-mn2) : DIV_W'(mn2);
    sd_nxt0.nmax = mx2[DIV_W-1] ? DIV_W'(-mx2) : DIV_W'(mx2);
    sd_nxt0.rmin = '0;
    sd_nxt0.rmax = '0;
    sd_nxt0.hw   = (req_width == '0) ? HW_W'(1) : req_width;
  end

  always_ff @(posedge clk) begin
    sd_r[0] <= sd_nxt0;
    for (int k = 0; k < STG; k++) begin
      {sd_r[k+1].rmin, sd_r[k+1].nmin} <= div_step(sd_r[k].rmin, sd_r[k].nmin, sd_r[k].hw);
      {sd_r[k+1].rmax, sd_r[k+1].nmax} <= div_step(sd_r[k].rmax, sd_r[k].nmax, sd_r[k].hw);
      sd_r[k+1].smin <= sd_r[k].smin;
      sd_r[k+1].smax <= sd_r[k].smax;
      sd_r[k+1].hw   <= sd_r[k].hw;
    end
    if (!rst_n) begin
      for (int k = 0; k <= STG; k++) sv_r[k] <= 1'b0;
    end else begin
      sv_r[0] <= take;
      for (int k = 0; k < STG; k++) sv_r[k+1] <= sv_r[k];
    end
  end

  assign fr_valid      = sv_r[STG];
  assign fr_word.qmin  = sd_r[STG].nmin;
  assign fr_word.rmin  = sd_r[STG].rmin;
  assign fr_word.nmin  = sd_r[STG].smin;
  assign fr_word.qmax  = sd_r[STG].nmax;
  assign fr_word.rmax  = sd_r[STG].rmax;
  assign fr_word.nmax  = sd_r[STG].smax;
  assign fr_word.hw    = sd_r[STG].hw;

endmodule
`default_nettype wire

### sv/hbra_queue.sv
// Two-word queue between the divider front end and the alignment back end.
// Depends on hbra_pkg.
`default_nettype none
module hbra_queue import hbra_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire hbra_div_t push_word,
  input  wire logic      pop,
  output logic           nonempty,
  output logic           full,
  output hbra_div_t      pop_word
);

  hbra_div_t mem [0:1];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= push_word;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop && nonempty) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop && nonempty);
    end
  end

  assign nonempty = (cnt_r != 2'd0);
  assign full     = (cnt_r == 2'd2);
  assign pop_word = mem[rp_r];

endmodule
`default_nettype wire

### sv/hbra_back.sv
// Back end: slack fix-up, span parity, odd alignment, end trim, scaling and saturation.
// Depends on hbra_pkg.
`default_nettype none
module hbra_back import hbra_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire hbra_div_t        in_word,
  output logic                  out_valid,
  output logic [OUT_W-1:0]      out_min,
  output logic [OUT_W-1:0]      out_max,
  output logic [CNT_W-1:0]      out_count
);

  typedef struct packed {
    lim_t lo;
    lim_t hi;
    slk_t ls;
    slk_t hs;
    slk_t hw;
  } al_t;

  typedef struct packed {
    logic [2*MAG_H+HW_W-1-MAG_H:0] lp_h;
    logic [MAG_H+HW_W-1:0]         lp_l;
    logic [2*MAG_H+HW_W-1-MAG_H:0] hp_h;
    logic [MAG_H+HW_W-1:0]         hp_l;
    logic                          lneg;
    logic                          hneg;
    logic [CNT_W-1:0]              cnt;
  } pp_t;

  typedef struct packed {
    logic [PRD_W-1:0] lp;
    logic [PRD_W-1:0] hp;
    logic             lneg;
    logic             hneg;
    logic [CNT_W-1:0] cnt;
  } pr_t;

  al_t  a_r, b_r, c_r, d_r, a_nxt, b_nxt, c_nxt, d_nxt;
  pp_t  e_r, e_nxt;
  pr_t  f_r, f_nxt;
  logic va_r, vb_r, vc_r, vd_r, ve_r, vf_r, vo_r;
  logic [OUT_W-1:0] omin_r, omax_r;
  logic [CNT_W-1:0] ocnt_r;

  function automatic logic [OUT_W-1:0] scale(input logic neg, input logic up,
      input logic [PRD_W-1:0] p);
    logic [PRD_W:0] h;
    h = up ? ({1'b0, p} + (PRD_W+1)'(1)) >> 1 : {1'b0, p} >> 1;
    if (neg) begin
      if (h > (PRD_W+1)'(1) << (OUT_W-1)) return {1'b1, {(OUT_W-1){1'b0}}};
      return OUT_W'(-h);
    end
    if (h > ((PRD_W+1)'(1) << (OUT_W-1)) - (PRD_W+1)'(1)) return {1'b0, {(OUT_W-1){1'b1}}};
    return h[OUT_W-1:0];
  endfunction

  always_comb begin
    lim_t qn, qx;
    slk_t rn, rx;
    qn = LIM_W'(in_word.qmin);
    qx = LIM_W'(in_word.qmax);
    rn = SLK_W'(in_word.rmin);
    rx = SLK_W'(in_word.rmax);
    a_nxt.hw = SLK_W'(in_word.hw);
    if (in_word.nmin && in_word.rmin != '0) begin
      a_nxt.lo = -qn - LIM_W'(1);
      a_nxt.ls = a_nxt.hw - rn;
    end else if (in_word.nmin) begin
      a_nxt.lo = -qn;
      a_nxt.ls = '0;
    end else begin
      a_nxt.lo = qn;
      a_nxt.ls = rn;
    end
    if (!in_word.nmax) begin
      a_nxt.hi = qx + LIM_W'(1);
      a_nxt.hs = a_nxt.hw - rx;
    end else begin
      a_nxt.hi = -qx + LIM_W'(1);
      a_nxt.hs = a_nxt.hw + rx;
    end
  end

  always_comb begin
    b_nxt = a_r;
    if (a_r.lo[0] ^ a_r.hi[0]) begin
      if (a_r.hs > a_r.ls) begin
        b_nxt.lo = a_r.lo - LIM_W'(1);
        b_nxt.ls = a_r.ls + a_r.hw;
      end else begin
        b_nxt.hi = a_r.hi + LIM_W'(1);
        b_nxt.hs = a_r.hs + a_r.hw;
      end
    end
  end

  always_comb begin
    c_nxt = b_r;
    if (!b_r.lo[0]) begin
      if (c_nxt.hs > c_nxt.ls && c_nxt.hs <= c_nxt.hw) begin
        c_nxt.lo = c_nxt.lo - LIM_W'(2);
        c_nxt.ls = c_nxt.ls + (c_nxt.hw <<< 1);
      end
      if (c_nxt.ls > c_nxt.hs && c_nxt.ls < c_nxt.hw) begin
        c_nxt.hi = c_nxt.hi + LIM_W'(2);
        c_nxt.hs = c_nxt.hs + (c_nxt.hw <<< 1);
      end
      if (c_nxt.hs > c_nxt.ls) begin
        c_nxt.lo = c_nxt.lo - LIM_W'(1);
        c_nxt.hi = c_nxt.hi - LIM_W'(1);
        c_nxt.hs = c_nxt.hs - c_nxt.hw;
        c_nxt.ls = c_nxt.ls + c_nxt.hw;
      end else begin
        c_nxt.lo = c_nxt.lo + LIM_W'(1);
        c_nxt.hi = c_nxt.hi + LIM_W'(1);
        c_nxt.ls = c_nxt.ls - c_nxt.hw;
        c_nxt.hs = c_nxt.hs + c_nxt.hw;
      end
    end
  end

  always_comb begin
    d_nxt = c_r;
    if (c_r.hs > (c_r.hw <<< 1)) begin
      d_nxt.hs = c_r.hs - (c_r.hw <<< 1);
      d_nxt.hi = c_r.hi - LIM_W'(2);
    end
    if (c_r.ls >= (c_r.hw <<< 1)) begin
      d_nxt.ls = c_r.ls - (c_r.hw <<< 1);
      d_nxt.lo = c_r.lo + LIM_W'(2);
    end
  end

  always_comb begin
    logic [LIM_W-1:0]         lm, hm;
    logic [HW_W-1:0]          w;
    logic signed [LIM_W:0]    span;
    logic [LIM_W-1:0]         s2;
    w  = d_r.hw[HW_W-1:0];
    lm = d_r.lo[LIM_W-1] ? LIM_W'(-d_r.lo) : LIM_W'(d_r.lo);
    hm = d_r.hi[LIM_W-1] ? LIM_W'(-d_r.hi) : LIM_W'(d_r.hi);
    e_nxt.lp_l = lm[MAG_H-1:0] * w;
    e_nxt.lp_h = lm[LIM_W-1:MAG_H] * w;
    e_nxt.hp_l = hm[MAG_H-1:0] * w;
    e_nxt.hp_h = hm[LIM_W-1:MAG_H] * w;
    e_nxt.lneg = d_r.lo[LIM_W-1];
    e_nxt.hneg = d_r.hi[LIM_W-1];
    span = (LIM_W+1)'(d_r.hi) - (LIM_W+1)'(d_r.lo);
    s2   = LIM_W'(span >>> 1);
    if (span <= 0) e_nxt.cnt = '0;
    else if (s2 > LIM_W'({CNT_W{1'b1}})) e_nxt.cnt = '1;
    else e_nxt.cnt = s2[CNT_W-1:0];
  end

  always_comb begin
    f_nxt.lp   = (PRD_W'(e_r.lp_h) << MAG_H) + PRD_W'(e_r.lp_l);
    f_nxt.hp   = (PRD_W'(e_r.hp_h) << MAG_H) + PRD_W'(e_r.hp_l);
    f_nxt.lneg = e_r.lneg;
    f_nxt.hneg = e_r.hneg;
    f_nxt.cnt  = e_r.cnt;
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    c_r    <= c_nxt;
    d_r    <= d_nxt;
    e_r    <= e_nxt;
    f_r    <= f_nxt;
    omin_r <= scale(f_r.lneg, f_r.lneg, f_r.lp);
    omax_r <= scale(f_r.hneg, !f_r.hneg, f_r.hp);
    ocnt_r <= f_r.cnt;
    if (!rst_n) begin
      {va_r, vb_r, vc_r, vd_r, ve_r, vf_r, vo_r} <= '0;
    end else begin
      {va_r, vb_r, vc_r, vd_r, ve_r, vf_r, vo_r} <= {in_valid, va_r, vb_r, vc_r, vd_r, ve_r, vf_r};
    end
  end

  assign out_valid = vo_r;
  assign out_min   = omin_r;
  assign out_max   = omax_r;
  assign out_count = ocnt_r;

endmodule
`default_nettype wire

### sv/histogram_bin_range_aligner_core.sv
// out_strobe follows the edge that accepts start through the front end, the queue and the back-end registers.
// Throughput: one word per cycle; the 49-stage divider pipeline sets the depth.
// busy stays low in use, since the back end drains the queue every cycle.
// Reset: synchronous, active low; clears valid flags, queue pointers and queue count only.
// Depends on hbra_pkg, hbra_front, hbra_queue, hbra_back.
`default_nettype none
module histogram_bin_range_aligner_core import hbra_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [HW_W-1:0]         in_bin_width,
  input  wire logic signed [OUT_W-1:0] in_data_min,
  input  wire logic signed [OUT_W-1:0] in_data_max,
  output logic                         out_strobe,
  output logic signed [OUT_W-1:0]      out_aligned_min,
  output logic signed [OUT_W-1:0]      out_aligned_max,
  output logic [CNT_W-1:0]             out_bin_count
);

  logic      fr_valid, q_nonempty, q_full;
  hbra_div_t fr_word, q_word;

  assign busy = q_full;

  hbra_front u_front (
    .clk, .rst_n,
    .take      (start && !busy),
    .req_width (in_bin_width),
    .data_min  (in_data_min),
    .data_max  (in_data_max),
    .fr_valid,
    .fr_word
  );

  hbra_queue u_queue (
    .clk, .rst_n,
    .push      (fr_valid),
    .push_word (fr_word),
    .pop       (q_nonempty),
    .nonempty  (q_nonempty),
    .full      (q_full),
    .pop_word  (q_word)
  );

  hbra_back u_back (
    .clk, .rst_n,
    .in_valid  (q_nonempty),
    .in_word   (q_word),
    .out_valid (out_strobe),
    .out_min   (out_aligned_min),
    .out_max   (out_aligned_max),
    .out_count (out_bin_count)
  );

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_full && fr_valid)) else $error("word pushed into full queue");

  a_count_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_bin_count != '0) |-> (out_aligned_max >= out_aligned_min))
    else $error("bins counted over an inverted range");

  a_quiet_reset: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_strobe) else $error("strobe straight after reset");

endmodule
`default_nettype wire

### verif/tb_top.sv
// Testbench for histogram_bin_range_aligner_core: random and directed range requests,
// checked against an in-bench predictor of the aligned range and bin count.
// Depends on hbra_pkg and the core RTL.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import hbra_pkg::*;

  localparam longint F_MAX = 64'sh7FFF_FFFF_FFFF;
  localparam longint F_MIN = -64'sh8000_0000_0000;
  localparam int WDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct {
    logic [31:0]        width;
    logic signed [47:0] lo;
    logic signed [47:0] hi;
  } req_t;

  typedef struct {
    logic signed [47:0] amin;
    logic signed [47:0] amax;
    logic [15:0]        count;
  } range_t;

  logic clk, rst_n, start, busy, out_strobe;
  logic [HW_W-1:0] in_bin_width;
  logic signed [OUT_W-1:0] in_data_min, in_data_max;
  logic signed [OUT_W-1:0] out_aligned_min, out_aligned_max;
  logic [CNT_W-1:0] out_bin_count;

  req_t   req_q[$];
  range_t range_q[$];
  int     errors = 0;
  int     idle_cycles = 0;
  int     gap = 0;
  bit     loaded = 0;
  bit     took = 0;

  histogram_bin_range_aligner_core uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_bin_width(in_bin_width), .in_data_min(in_data_min), .in_data_max(in_data_max),
    .out_strobe(out_strobe), .out_aligned_min(out_aligned_min),
    .out_aligned_max(out_aligned_max), .out_bin_count(out_bin_count)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // limit * hw / 2, rounded as asked, saturated to 48 bits
  function automatic longint scale_limit(longint limit, longint hw, bit round_up);
    bit neg;
    logic [63:0] mag, prod, half;
    neg = limit < 0;
    mag = neg ? -limit : limit;
    if (mag > (64'h7FFF_FFFF_FFFF_FFFF / hw)) return neg ? F_MIN : F_MAX;
    prod = mag * hw;
    if (neg) begin
      half = round_up ? (prod >> 1) : ((prod + 1) >> 1);
      if (half > 64'h8000_0000_0000) return F_MIN;
      return -longint'(half);
    end
    half = round_up ? ((prod + 1) >> 1) : (prod >> 1);
    if (half > F_MAX) return F_MAX;
    return longint'(half);
  endfunction

  function automatic range_t align_range(req_t r);
    longint hw, mn2, mx2, lo, hi, ls, hs, span;
    range_t res;
    hw = (r.width == 0) ? 1 : longint'({32'd0, r.width});
    mn2 = longint'(r.lo) * 2;
    mx2 = longint'(r.hi) * 2;
    lo = mn2 / hw;
    ls = mn2 - lo * hw;
    hi = mx2 / hw;
    hs = -(mx2 - hi * hw);
    if (ls < 0) begin
      lo--;
      ls += hw;
    end
    hi++;
    hs += hw;
    if ((hi - lo) & 1) begin
      if (hs > ls) begin
        lo--;
        ls += hw;
      end else begin
        hi++;
        hs += hw;
      end
    end
    if ((lo & 1) == 0) begin
      if (hs > ls && hs <= hw) begin
        lo -= 2;
        ls += 2 * hw;
      end
      if (ls > hs && ls < hw) begin
        hi += 2;
        hs += 2 * hw;
      end
      if (hs > ls) begin
        lo--;
        hi--;
        hs -= hw;
        ls += hw;
      end else begin
        lo++;
        hi++;
        ls -= hw;
        hs += hw;
      end
    end
    if (hs > 2 * hw) begin
      hs -= 2 * hw;
      hi -= 2;
    end
    if (ls >= 2 * hw) begin
      ls -= 2 * hw;
      lo += 2;
    end
    res.amin = 48'(scale_limit(lo, hw, 1'b0));
    res.amax = 48'(scale_limit(hi, hw, 1'b1));
    span = hi - lo;
    if (span <= 0) res.count = 0;
    else if (span / 2 > 65535) res.count = 16'hFFFF;
    else res.count = 16'(span / 2);
    return res;
  endfunction

  function automatic logic [47:0] rand48();
    return {16'($urandom_range(16'hFFFF, 0)), $urandom()};
  endfunction

  task automatic push(logic [31:0] w, logic signed [47:0] a, logic signed [47:0] b);
    req_t r;
    r.width = w;
    r.lo = a;
    r.hi = b;
    req_q.push_back(r);
  endtask

  initial begin
    logic [31:0] w;
    logic signed [47:0] a, d;
    push(32'd0, 48'sd0, 48'sd5);
    push(32'd1, 48'(F_MIN), 48'(F_MAX));
    push(32'hFFFF_FFFF, 48'(F_MIN), 48'(F_MAX));
    push(32'hFFFF_FFFF, -48'sd1, 48'sd1);
    push(32'd3, -48'sd7, 48'sd11);
    push(32'd5, 48'sd4, 48'sd4);
    push(32'd65536, 48'sd100, -48'sd100);
    push(32'h0001_0000, 48'sh0000_0000_0000, 48'sh0000_0010_0000);
    push(32'd1, 48'(F_MAX), 48'(F_MAX));
    push(32'd7, 48'(F_MIN), 48'(F_MIN + 1));
    push(32'd2, 48'sd0, 48'sd1);
    push(32'd131072, -48'sd65536, 48'sd65536);
    push(32'h8000_0001, 48'sh5555_5555_5555, -48'sh5555_5555_5555);
    push(32'h5555_5555, 48'sh2AAA_AAAA_AAAA, 48'sh2AAA_AAAA_AAAB);
    repeat (550) begin
      case ($urandom_range(3, 0))
        0: w = $urandom();
        1: w = $urandom_range(16, 0);
        default: w = $urandom_range(32'h0010_0000, 1);
      endcase
      a = ($urandom_range(1, 0)) ? rand48() : $signed(48'($signed($urandom())));
      case ($urandom_range(3, 0))
        0: d = rand48();
        1: d = 48'(a + $urandom_range(16, 0));
        default: d = 48'(a + w * $urandom_range(200, 1) + $urandom_range(3, 0));
      endcase
      push(w, a, d);
    end
    loaded = 1;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_bin_width <= '0;
      in_data_min <= '0;
      in_data_max <= '0;
    end else if (took) begin
      if (req_q.size() > 0) req_q.pop_front();
      if (gap == 0 && req_q.size() > 0) begin
        in_bin_width <= req_q[0].width;
        in_data_min <= req_q[0].lo;
        in_data_max <= req_q[0].hi;
      end else begin
        start <= 1'b0;
      end
      gap = ($urandom_range(3, 0) == 0) ? $urandom_range(15, 0) : 0;
    end else if (!start) begin
      if (gap > 0) gap--;
      else if (req_q.size() > 0) begin
        start <= 1'b1;
        in_bin_width <= req_q[0].width;
        in_data_min <= req_q[0].lo;
        in_data_max <= req_q[0].hi;
      end
    end
  end

  always @(posedge clk) begin
    range_t exp_r;
    if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
      took <= start && !busy;
      if (start && !busy) begin
        req_t r;
        r.width = in_bin_width;
        r.lo = in_data_min;
        r.hi = in_data_max;
        range_q.push_back(align_range(r));
        idle_cycles <= 0;
      end
      if (out_strobe) begin
        idle_cycles <= 0;
        if (range_q.size() == 0) begin
          $display("%0t: unexpected word min=%0d max=%0d count=%0d", $realtime,
                   out_aligned_min, out_aligned_max, out_bin_count);
          errors++;
        end else begin
          exp_r = range_q.pop_front();
          if (out_aligned_min !== exp_r.amin) begin
            $display("%0t: aligned_min exp %0d got %0d", $realtime, exp_r.amin,
                     out_aligned_min);
            errors++;
          end
          if (out_aligned_max !== exp_r.amax) begin
            $display("%0t: aligned_max exp %0d got %0d", $realtime, exp_r.amax,
                     out_aligned_max);
            errors++;
          end
          if (out_bin_count !== exp_r.count) begin
            $display("%0t: bin_count exp %0d got %0d", $realtime, exp_r.count,
                     out_bin_count);
            errors++;
          end
        end
      end
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end else begin
      took <= 1'b0;
    end
  end

  initial begin
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    wait (loaded && req_q.size() == 0 && !start);
    wait (range_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && range_q.size() == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end
endmodule
`default_nettype wire

### files.f
sv/hbra_pkg.sv
sv/hbra_front.sv
sv/hbra_queue.sv
sv/hbra_back.sv
sv/histogram_bin_range_aligner_core.sv
verif/tb_top.sv
